FILE: design/pmm_pkg.sv
// Shared types and constants for the modular polynomial multiplier.
// No dependencies; every other design file imports this package.
`default_nettype none
package pmm_pkg;

   // Field widths of the transaction payloads.
   localparam int COEF_W = 31;
   localparam int IDX_W  = 11;

   // Number of conditional-subtract steps needed to reduce modulo a 31-bit modulus.
   localparam int RED_STEPS = 31;

   // Request codes.
   localparam logic [1:0] REQ_CLEAR  = 2'd0;
   localparam logic [1:0] REQ_LOAD_A = 2'd1;
   localparam logic [1:0] REQ_LOAD_B = 2'd2;
   localparam logic [1:0] REQ_READ   = 2'd3;

   // Reset value of the modulus register.
   localparam logic [COEF_W-1:0] MODULUS_RESET = 31'd1000000007;

   typedef struct packed {
      logic [1:0]        req_type;
      logic [IDX_W-1:0]  index;
      logic [COEF_W-1:0] value;
   } pmm_req_type;

   typedef struct packed {
      logic [COEF_W-1:0] product_coef;
      logic [IDX_W-1:0]  product_length;
   } pmm_rsp_type;

   // Sideband that travels with each term through the reduction cells.
   typedef struct packed {
      logic valid;
      logic last;
   } pmm_tag_type;

endpackage
`default_nettype wire

FILE: design/modular_polynomial_multiplier_top.sv
// Top level of the modular polynomial multiplier: stores, sequencer and accumulator.
// Depends on pmm_pkg and pmm_chain (which uses pmm_cell).
//
// Every request gives one response on rsp_strobe, which the receiver cannot stall.
// A load writes the store directly; a zero load at the top coefficient walks the
// store down entry by entry to find the new length. A clear sweeps both stores,
// and after reset the same sweep runs once (busy high) before the first request
// is taken. A read of coefficient k streams one term per cycle from both stores
// through a row of 31 cells that reduce the operands, a multiplier, a second row
// of 31 cells that reduce the product, and an accumulator, for up to MAX_TERMS
// terms. A read beyond the product answers with zero without streaming.
`default_nettype none
module modular_polynomial_multiplier_top #(
   parameter int MAX_TERMS = 1024
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   output logic                                busy,
   input  wire pmm_pkg::pmm_req_type           req_data,
   output logic                                rsp_strobe,
   output pmm_pkg::pmm_rsp_type                rsp_data,
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [pmm_pkg::COEF_W-1:0]     csr_data
);
   import pmm_pkg::*;

   localparam int AW = $clog2(MAX_TERMS);
   localparam int LW = $clog2(MAX_TERMS + 1);
   localparam int SW = ((LW > IDX_W) ? LW : IDX_W) + 1;
   localparam int PW = 2 * COEF_W;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_CLEAR = 3'd1;
   localparam logic [2:0] ST_TRIM  = 3'd2;
   localparam logic [2:0] ST_READ  = 3'd3;
   localparam logic [2:0] ST_DRAIN = 3'd4;

   // Coefficient stores.
   logic [COEF_W-1:0] a_mem [MAX_TERMS];
   logic [COEF_W-1:0] b_mem [MAX_TERMS];

   logic [2:0]        state_ff, state_in;
   logic [AW-1:0]     sweep_ff, sweep_in;
   logic              clr_rsp_ff, clr_rsp_in;
   logic              trim_b_ff, trim_b_in;
   logic [LW-1:0]     scan_ff, scan_in;
   logic              phase_ff, phase_in;
   logic [SW-1:0]     i_ff, i_in;
   logic [SW-1:0]     hi_ff, hi_in;
   logic [SW-1:0]     k_ff, k_in;
   logic [LW-1:0]     a_len_ff, a_len_in;
   logic [LW-1:0]     b_len_ff, b_len_in;
   logic [COEF_W-1:0] modulus_ff;
   logic              rsp_strobe_ff, rsp_strobe_in;
   logic [COEF_W-1:0] rsp_coef_ff, rsp_coef_in;
   logic [COEF_W-1:0] acc_ff, acc_in;
   pmm_tag_type       tag_rd_ff, tag_rd_in;

   logic              a_we, b_we;
   logic [AW-1:0]     a_waddr, b_waddr;
   logic [COEF_W-1:0] a_wdata, b_wdata;
   logic [AW-1:0]     a_raddr, b_raddr;
   logic [COEF_W-1:0] a_rd_ff, b_rd_ff;

   logic              accept;
   logic [SW-1:0]     idx_ext, idx_p1, plen_full, a_top, b_top, lo, hi, diff_ki;
   logic [SW-1:0]     scan_m1;
   logic              idx_in_store;
   logic [COEF_W-1:0] trim_data;

   pmm_tag_type                  xy_tag;
   logic [1:0][COEF_W-1:0]       xy_in, xy_out;
   pmm_tag_type                  mul_tag_ff;
   logic [PW-1:0]                prod_ff;
   pmm_tag_type                  p_tag;
   logic [0:0][PW-1:0]           p_out;
   logic [COEF_W:0]              sum, acc_next;

   assign accept    = start && !busy;
   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;

   // Request decode and term bounds of a read.
   assign idx_ext      = SW'(req_data.index);
   assign idx_p1       = idx_ext + SW'(1);
   assign idx_in_store = (idx_ext < SW'(MAX_TERMS));
   assign plen_full    = SW'(a_len_ff) + SW'(b_len_ff) - SW'(1);
   assign a_top        = SW'(a_len_ff) - SW'(1);
   assign b_top        = SW'(b_len_ff) - SW'(1);
   assign lo           = (idx_ext >= b_top) ? (idx_ext - b_top) : '0;
   assign hi           = (idx_ext < a_top) ? idx_ext : a_top;
   assign diff_ki      = k_ff - i_ff;
   assign scan_m1      = SW'(scan_ff) - SW'(1);
   assign trim_data    = trim_b_ff ? b_rd_ff : a_rd_ff;

   // Accumulation of a reduced product term.
   assign sum      = {1'b0, acc_ff} + {1'b0, p_out[0][COEF_W-1:0]};
   assign acc_next = (sum >= {1'b0, modulus_ff}) ? (sum - {1'b0, modulus_ff}) : sum;

   // Sequencer next-state logic.
   always_comb begin
      state_in      = state_ff;
      sweep_in      = sweep_ff;
      clr_rsp_in    = clr_rsp_ff;
      trim_b_in     = trim_b_ff;
      scan_in       = scan_ff;
      phase_in      = phase_ff;
      i_in          = i_ff;
      hi_in         = hi_ff;
      k_in          = k_ff;
      a_len_in      = a_len_ff;
      b_len_in      = b_len_ff;
      rsp_strobe_in = 1'b0;
      rsp_coef_in   = rsp_coef_ff;
      acc_in        = acc_ff;
      tag_rd_in     = '0;
      a_we          = 1'b0;
      b_we          = 1'b0;
      a_waddr       = req_data.index[AW-1:0];
      b_waddr       = req_data.index[AW-1:0];
      a_wdata       = req_data.value;
      b_wdata       = req_data.value;
      a_raddr       = scan_m1[AW-1:0];
      b_raddr       = scan_m1[AW-1:0];

      // Terms leaving the product reduction fold into the accumulator.
      if (p_tag.valid) begin
         acc_in = acc_next[COEF_W-1:0];
         if (p_tag.last) begin
            rsp_strobe_in = 1'b1;
            rsp_coef_in   = (modulus_ff < COEF_W'(2)) ? '0 : acc_next[COEF_W-1:0];
            state_in      = ST_IDLE;
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_data.req_type)
                  REQ_CLEAR: begin
                     state_in   = ST_CLEAR;
                     sweep_in   = '0;
                     clr_rsp_in = 1'b1;
                     a_len_in   = LW'(1);
                     b_len_in   = LW'(1);
                  end
                  REQ_LOAD_A, REQ_LOAD_B: begin
                     trim_b_in   = (req_data.req_type == REQ_LOAD_B);
                     rsp_strobe_in = 1'b1;
                     rsp_coef_in = '0;
                     if (idx_in_store) begin
                        a_we = (req_data.req_type == REQ_LOAD_A);
                        b_we = (req_data.req_type == REQ_LOAD_B);
                        if (req_data.value != '0) begin
                           if (a_we && (idx_p1 > SW'(a_len_ff))) begin
                              a_len_in = idx_p1[LW-1:0];
                           end
                           if (b_we && (idx_p1 > SW'(b_len_ff))) begin
                              b_len_in = idx_p1[LW-1:0];
                           end
                        end else if ((idx_ext != '0) &&
                                     ((a_we && (idx_p1 == SW'(a_len_ff))) ||
                                      (b_we && (idx_p1 == SW'(b_len_ff))))) begin
                           // Top coefficient zeroed: walk down for the new length.
                           rsp_strobe_in = 1'b0;
                           state_in      = ST_TRIM;
                           scan_in       = idx_ext[LW-1:0];
                           phase_in      = 1'b0;
                        end
                     end
                  end
                  REQ_READ: begin
                     if (idx_ext < plen_full) begin
                        state_in = ST_READ;
                        i_in     = lo;
                        hi_in    = hi;
                        k_in     = idx_ext;
                        acc_in   = '0;
                     end else begin
                        rsp_strobe_in = 1'b1;
                        rsp_coef_in   = '0;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_CLEAR: begin
            a_we    = 1'b1;
            b_we    = 1'b1;
            a_waddr = sweep_ff;
            b_waddr = sweep_ff;
            a_wdata = '0;
            b_wdata = '0;
            sweep_in = sweep_ff + AW'(1);
            if (sweep_ff == AW'(MAX_TERMS - 1)) begin
               state_in      = ST_IDLE;
               rsp_strobe_in = clr_rsp_ff;
               rsp_coef_in   = '0;
               clr_rsp_in    = 1'b0;
            end
         end
         ST_TRIM: begin
            if (!phase_ff) begin
               if (scan_ff == LW'(1)) begin
                  if (trim_b_ff) begin
                     b_len_in = LW'(1);
                  end else begin
                     a_len_in = LW'(1);
                  end
                  state_in      = ST_IDLE;
                  rsp_strobe_in = 1'b1;
                  rsp_coef_in   = '0;
               end else begin
                  phase_in = 1'b1;
               end
            end else begin
               phase_in = 1'b0;
               if (trim_data != '0) begin
                  if (trim_b_ff) begin
                     b_len_in = scan_ff;
                  end else begin
                     a_len_in = scan_ff;
                  end
                  state_in      = ST_IDLE;
                  rsp_strobe_in = 1'b1;
                  rsp_coef_in   = '0;
               end else begin
                  scan_in = scan_ff - LW'(1);
               end
            end
         end
         ST_READ: begin
            a_raddr   = i_ff[AW-1:0];
            b_raddr   = diff_ki[AW-1:0];
            tag_rd_in = '{valid: 1'b1, last: (i_ff == hi_ff)};
            i_in      = i_ff + SW'(1);
            if (i_ff == hi_ff) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         sweep_ff      <= '0;
         clr_rsp_ff    <= 1'b0;
         a_len_ff      <= LW'(1);
         b_len_ff      <= LW'(1);
         modulus_ff    <= MODULUS_RESET;
         rsp_strobe_ff <= 1'b0;
         tag_rd_ff     <= '0;
         mul_tag_ff    <= '0;
      end else begin
         state_ff      <= state_in;
         sweep_ff      <= sweep_in;
         clr_rsp_ff    <= clr_rsp_in;
         a_len_ff      <= a_len_in;
         b_len_ff      <= b_len_in;
         rsp_strobe_ff <= rsp_strobe_in;
         tag_rd_ff     <= tag_rd_in;
         mul_tag_ff    <= xy_tag;
         if (csr_valid && csr_ready) begin
            modulus_ff <= csr_data;
         end
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      trim_b_ff   <= trim_b_in;
      scan_ff     <= scan_in;
      phase_ff    <= phase_in;
      i_ff        <= i_in;
      hi_ff       <= hi_in;
      k_ff        <= k_in;
      rsp_coef_ff <= rsp_coef_in;
      acc_ff      <= acc_in;
      prod_ff     <= PW'(xy_out[0]) * PW'(xy_out[1]);
   end

   // Store A.
   always_ff @(posedge clock) begin
      if (a_we) begin
         a_mem[a_waddr] <= a_wdata;
      end
      a_rd_ff <= a_mem[a_raddr];
   end

   // Store B.
   always_ff @(posedge clock) begin
      if (b_we) begin
         b_mem[b_waddr] <= b_wdata;
      end
      b_rd_ff <= b_mem[b_raddr];
   end

   // Operand reduction row, both operands side by side.
   assign xy_in[0] = a_rd_ff;
   assign xy_in[1] = b_rd_ff;

   pmm_chain #(
      .W     (COEF_W),
      .LANES (2)
   ) u_xy_chain (
      .clock    (clock),
      .reset    (reset),
      .m        (modulus_ff),
      .in_tag   (tag_rd_ff),
      .in_data  (xy_in),
      .out_tag  (xy_tag),
      .out_data (xy_out)
   );

   // Product reduction row.
   pmm_chain #(
      .W     (PW),
      .LANES (1)
   ) u_p_chain (
      .clock    (clock),
      .reset    (reset),
      .m        (modulus_ff),
      .in_tag   (mul_tag_ff),
      .in_data  (prod_ff),
      .out_tag  (p_tag),
      .out_data (p_out)
   );

   // Response transaction.
   assign rsp_strobe              = rsp_strobe_ff;
   assign rsp_data.product_coef   = rsp_coef_ff;
   assign rsp_data.product_length = plen_full[IDX_W-1:0];

endmodule
`default_nettype wire

FILE: design/pmm_cell.sv
// One reduction cell: a conditional subtract of the modulus shifted left by SHIFT.
// Depends on pmm_pkg for the sideband type and the modulus width.
`default_nettype none
module pmm_cell #(
   parameter int W     = 31,
   parameter int LANES = 1,
   parameter int SHIFT = 0
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [pmm_pkg::COEF_W-1:0]    m,
   input  wire pmm_pkg::pmm_tag_type          in_tag,
   input  wire logic [LANES-1:0][W-1:0]       in_data,
   output pmm_pkg::pmm_tag_type               out_tag,
   output logic      [LANES-1:0][W-1:0]       out_data
);
   import pmm_pkg::*;

   localparam int CW = ((W > COEF_W + SHIFT) ? W : COEF_W + SHIFT) + 1;

   logic [CW-1:0]           mm;
   logic [LANES-1:0][W-1:0] res;
   pmm_tag_type             tag_ff;
   logic [LANES-1:0][W-1:0] data_ff;

   // Shifted modulus shared by all lanes.
   assign mm = CW'(m) << SHIFT;

   // Each lane subtracts the shifted modulus when it fits.
   for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [CW-1:0] rext;
      logic [CW-1:0] diff;
      assign rext   = CW'(in_data[l]);
      assign diff   = rext - mm;
      assign res[l] = (rext >= mm) ? diff[W-1:0] : in_data[l];
   end

   // Stage register handing the partial remainder to the next cell.
   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff <= '0;
      end else begin
         tag_ff <= in_tag;
      end
      data_ff <= res;
   end

   assign out_tag  = tag_ff;
   assign out_data = data_ff;

endmodule
`default_nettype wire

FILE: design/pmm_chain.sv
// A row of reduction cells that reduces each lane modulo m, one shift per cell.
// Depends on pmm_pkg and pmm_cell.
`default_nettype none
module pmm_chain #(
   parameter int W     = 31,
   parameter int LANES = 1
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [pmm_pkg::COEF_W-1:0]    m,
   input  wire pmm_pkg::pmm_tag_type          in_tag,
   input  wire logic [LANES-1:0][W-1:0]       in_data,
   output pmm_pkg::pmm_tag_type               out_tag,
   output logic      [LANES-1:0][W-1:0]       out_data
);
   import pmm_pkg::*;

   pmm_tag_type             tags [RED_STEPS+1];
   logic [LANES-1:0][W-1:0] dat  [RED_STEPS+1];

   assign tags[0] = in_tag;
   assign dat[0]  = in_data;

   // Cells run from the largest shift down to shift zero.
   for (genvar s = 0; s < RED_STEPS; s++) begin : g_cell
      pmm_cell #(
         .W     (W),
         .LANES (LANES),
         .SHIFT (RED_STEPS - 1 - s)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .m        (m),
         .in_tag   (tags[s]),
         .in_data  (dat[s]),
         .out_tag  (tags[s+1]),
         .out_data (dat[s+1])
      );
   end

   assign out_tag  = tags[RED_STEPS];
   assign out_data = dat[RED_STEPS];

endmodule
`default_nettype wire
